FILE: rtl/core/lpwf_pkg.sv
package lpwf_pkg;

    localparam int DEFAULT_MAX_CHANNELS = 16;

    localparam int CFG_ADDR_W = 4;
    localparam int NUM_CH_W   = 5;
    localparam int ENABLE_W   = 16;
    localparam int NUM_LEDS_W = 15;
    localparam int ORDER_W    = 8;

    localparam int CHANNEL_W  = 5;
    localparam int LED_W      = 16;
    localparam int COLOR_W    = 8;
    localparam int LEVEL_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int WIDX_W     = 19;
    localparam int WORD_W     = 32;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_NUM_CHANNELS   = 2'd0;
    localparam logic [1:0] REG_CHANNEL_ENABLE = 2'd1;
    localparam logic [1:0] REG_NUM_LEDS       = 2'd2;
    localparam logic [1:0] REG_COLOR_ORDER    = 2'd3;

    localparam logic REQ_PIXEL      = 1'b0;
    localparam logic REQ_BRIGHTNESS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_CHANNEL = 2'd1,
        STATUS_DISABLED    = 2'd2,
        STATUS_LED_RANGE   = 2'd3
    } status_t;

    typedef struct packed {
        logic [NUM_CH_W-1:0]   num_channels;
        logic [ENABLE_W-1:0]   channel_enable;
        logic [NUM_LEDS_W-1:0] num_leds;
        logic [ORDER_W-1:0]    color_order;
    } cfg_t;

    typedef struct packed {
        logic                 req_type;
        logic [CHANNEL_W-1:0] channel;
        logic [LED_W-1:0]     led_index;
        logic [COLOR_W-1:0]   red;
        logic [COLOR_W-1:0]   green;
        logic [COLOR_W-1:0]   blue;
        logic [COLOR_W-1:0]   white;
        logic [LEVEL_W-1:0]   level;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic                write_valid;
        logic [WIDX_W-1:0]   word_index;
        logic [WORD_W-1:0]   pixel_word;
    } rsp_t;

    // level zero means pass-through
    function automatic logic [COLOR_W-1:0] scale_color(
        input logic [COLOR_W-1:0] c,
        input logic [LEVEL_W-1:0] lvl
    );
        logic [COLOR_W+LEVEL_W-1:0] prod;
        prod = (COLOR_W+LEVEL_W)'(c) * (COLOR_W+LEVEL_W)'(lvl);
        if (lvl == '0) begin
            return c;
        end
        return prod[COLOR_W+LEVEL_W-1:LEVEL_W];
    endfunction

endpackage

FILE: rtl/core/led_pixel_word_formatter_top.sv
// From s_valid/s_ready to m_valid: input register, then result register.
// One item per cycle unless m_ready stalls; check, scale and pack sit in one stage.
// A brightness write is stored as the item leaves the input register, so the next
// pixel item on that channel already sees the new level.
// Reset (aresetn low, synchronous): pipeline empty, all brightness levels zero,
// num_channels = 1, the other registers zero.
module led_pixel_word_formatter_top #(
    parameter int MAX_CHANNELS = lpwf_pkg::DEFAULT_MAX_CHANNELS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpwf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [lpwf_pkg::CHANNEL_W-1:0]  s_channel,
    input  logic [lpwf_pkg::LED_W-1:0]      s_led_index,
    input  logic [lpwf_pkg::COLOR_W-1:0]    s_red,
    input  logic [lpwf_pkg::COLOR_W-1:0]    s_green,
    input  logic [lpwf_pkg::COLOR_W-1:0]    s_blue,
    input  logic [lpwf_pkg::COLOR_W-1:0]    s_white,
    input  logic [lpwf_pkg::LEVEL_W-1:0]    s_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [lpwf_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_write_valid,
    output logic [lpwf_pkg::WIDX_W-1:0]     m_word_index,
    output logic [lpwf_pkg::WORD_W-1:0]     m_pixel_word
);
    import lpwf_pkg::*;

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    cfg_t               cfg;
    req_t               in_req;
    rsp_t               out_rsp;
    logic               bright_we;
    logic [IDX_W-1:0]   bright_waddr;
    logic [IDX_W-1:0]   bright_raddr;
    logic [LEVEL_W-1:0] bright_wdata;
    logic [LEVEL_W-1:0] bright_rdata;

    assign in_req.req_type  = s_req_type;
    assign in_req.channel   = s_channel;
    assign in_req.led_index = s_led_index;
    assign in_req.red       = s_red;
    assign in_req.green     = s_green;
    assign in_req.blue      = s_blue;
    assign in_req.white     = s_white;
    assign in_req.level     = s_level;

    assign m_status      = out_rsp.status;
    assign m_write_valid = out_rsp.write_valid;
    assign m_word_index  = out_rsp.word_index;
    assign m_pixel_word  = out_rsp.pixel_word;

    lpwf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lpwf_bright_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_bright (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (bright_we),
        .waddr   (bright_waddr),
        .wdata   (bright_wdata),
        .raddr   (bright_raddr),
        .rdata   (bright_rdata)
    );

    lpwf_formatter #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_fmt (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_req       (in_req),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_rsp      (out_rsp),
        .bright_we    (bright_we),
        .bright_waddr (bright_waddr),
        .bright_wdata (bright_wdata),
        .bright_raddr (bright_raddr),
        .bright_rdata (bright_rdata)
    );

endmodule

FILE: rtl/core/lpwf_apb_regs.sv
module lpwf_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lpwf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output lpwf_pkg::cfg_t                  cfg
);
    import lpwf_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_channels   <= NUM_CH_W'(1);
            cfg_reg.channel_enable <= '0;
            cfg_reg.num_leds       <= '0;
            cfg_reg.color_order    <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUM_CHANNELS:   cfg_reg.num_channels   <= pwdata[NUM_CH_W-1:0];
                REG_CHANNEL_ENABLE: cfg_reg.channel_enable <= pwdata[ENABLE_W-1:0];
                REG_NUM_LEDS:       cfg_reg.num_leds       <= pwdata[NUM_LEDS_W-1:0];
                REG_COLOR_ORDER:    cfg_reg.color_order    <= pwdata[ORDER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_NUM_CHANNELS:   prdata = 32'(cfg_reg.num_channels);
            REG_CHANNEL_ENABLE: prdata = 32'(cfg_reg.channel_enable);
            REG_NUM_LEDS:       prdata = 32'(cfg_reg.num_leds);
            REG_COLOR_ORDER:    prdata = 32'(cfg_reg.color_order);
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/lpwf_bright_store.sv
module lpwf_bright_store #(
    parameter int MAX_CHANNELS = lpwf_pkg::DEFAULT_MAX_CHANNELS,
    parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         we,
    input  logic [IDX_W-1:0]             waddr,
    input  logic [lpwf_pkg::LEVEL_W-1:0] wdata,
    input  logic [IDX_W-1:0]             raddr,
    output logic [lpwf_pkg::LEVEL_W-1:0] rdata
);
    import lpwf_pkg::*;

    logic [LEVEL_W-1:0] level_reg [MAX_CHANNELS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                level_reg[i] <= '0;
            end
        end else if (we) begin
            level_reg[waddr] <= wdata;
        end
    end

    // callers must only address entries below MAX_CHANNELS; this block does not enforce it
    assign rdata = level_reg[raddr];

endmodule

FILE: rtl/core/lpwf_formatter.sv
module lpwf_formatter #(
    parameter int MAX_CHANNELS = lpwf_pkg::DEFAULT_MAX_CHANNELS,
    parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lpwf_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lpwf_pkg::req_t               in_req,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lpwf_pkg::rsp_t               out_rsp,
    output logic                         bright_we,
    output logic [IDX_W-1:0]             bright_waddr,
    output logic [lpwf_pkg::LEVEL_W-1:0] bright_wdata,
    output logic [IDX_W-1:0]             bright_raddr,
    input  logic [lpwf_pkg::LEVEL_W-1:0] bright_rdata
);
    import lpwf_pkg::*;

    localparam int PROD_W = NUM_CH_W + LED_W;

    logic  req_valid_reg;
    req_t  req_reg;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic  advance;

    status_t            ch_status;
    logic [COLOR_W-1:0] r_s, g_s, b_s, w_s;
    logic [1:0]         wsel, rsel, gsel, bsel;
    logic [WORD_W-1:0]  word;
    logic [PROD_W-1:0]  idx_prod;
    logic [PROD_W-1:0]  idx_sum;

    assign advance  = req_valid_reg && (!rsp_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                req_valid_reg <= in_valid;
            end
            if (advance) begin
                rsp_valid_reg <= 1'b1;
            end else if (out_ready) begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            req_reg <= in_req;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

    // channel checks: count first, then mask (channels 16 and up have no mask bit)
    always_comb begin
        if ((req_reg.channel >= cfg.num_channels) ||
            (32'(req_reg.channel) >= 32'(MAX_CHANNELS))) begin
            ch_status = STATUS_BAD_CHANNEL;
        end else if (req_reg.channel[4] || !cfg.channel_enable[req_reg.channel[3:0]]) begin
            ch_status = STATUS_DISABLED;
        end else begin
            ch_status = STATUS_OK;
        end
    end

    assign bright_raddr = req_reg.channel[IDX_W-1:0];
    assign bright_waddr = req_reg.channel[IDX_W-1:0];
    assign bright_wdata = req_reg.level;
    assign bright_we    = advance && (req_reg.req_type == REQ_BRIGHTNESS) &&
                          (ch_status == STATUS_OK);

    assign r_s = scale_color(req_reg.red,   bright_rdata);
    assign g_s = scale_color(req_reg.green, bright_rdata);
    assign b_s = scale_color(req_reg.blue,  bright_rdata);
    assign w_s = scale_color(req_reg.white, bright_rdata);

    assign wsel = cfg.color_order[7:6];
    assign rsel = cfg.color_order[5:4];
    assign gsel = cfg.color_order[3:2];
    assign bsel = cfg.color_order[1:0];

    // overlapping positions OR together; white drops out in 24-bit mode
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            word[k*8 +: 8] = ((rsel == 2'(k)) ? r_s : 8'h00) |
                             ((gsel == 2'(k)) ? g_s : 8'h00) |
                             ((bsel == 2'(k)) ? b_s : 8'h00) |
                             (((wsel == 2'(k)) && (wsel != rsel)) ? w_s : 8'h00);
        end
    end

    assign idx_prod = PROD_W'(cfg.num_channels) * PROD_W'(req_reg.led_index);
    assign idx_sum  = idx_prod + PROD_W'(req_reg.channel);

    always_comb begin
        rsp_next             = '0;
        rsp_next.status      = ch_status;
        if (req_reg.req_type == REQ_PIXEL && ch_status == STATUS_OK) begin
            if (req_reg.led_index >= LED_W'(cfg.num_leds)) begin
                rsp_next.status = STATUS_LED_RANGE;
            end else begin
                rsp_next.write_valid = 1'b1;
                rsp_next.word_index  = idx_sum[WIDX_W-1:0];
                rsp_next.pixel_word  = word;
            end
        end
    end

    assign out_valid = rsp_valid_reg;
    assign out_rsp   = rsp_reg;

endmodule

FILE: verif/led_pixel_word_formatter_top_tb.sv
`timescale 1ns / 1ps

module led_pixel_word_formatter_top_tb;
    import lpwf_pkg::*;

    localparam int MAX_CH      = DEFAULT_MAX_CHANNELS;
    localparam int RUN_LIMIT   = 300000;
    localparam int HOLD_CYCLES = 150;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = REQ_PIXEL;
    logic [CHANNEL_W-1:0]  s_channel = '0;
    logic [LED_W-1:0]      s_led_index = '0;
    logic [COLOR_W-1:0]    s_red = '0;
    logic [COLOR_W-1:0]    s_green = '0;
    logic [COLOR_W-1:0]    s_blue = '0;
    logic [COLOR_W-1:0]    s_white = '0;
    logic [LEVEL_W-1:0]    s_level = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic                  m_write_valid;
    logic [WIDX_W-1:0]     m_word_index;
    logic [WORD_W-1:0]     m_pixel_word;

    led_pixel_word_formatter_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_channel     (s_channel),
        .s_led_index   (s_led_index),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_white       (s_white),
        .s_level       (s_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_write_valid (m_write_valid),
        .m_word_index  (m_word_index),
        .m_pixel_word  (m_pixel_word)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // mirrors of the register file and the per-channel brightness
    cfg_t               cfg_mirror;
    logic [LEVEL_W-1:0] level_mirror [MAX_CH];

    req_t pixel_reqs_q [$];
    rsp_t formatted_q [$];

    int accepted_cnt = 0;
    int rsp_cnt = 0;
    int fail_cnt = 0;
    int cycle_cnt;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  stall_tick = '0;

    function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c,
                                                      input logic [LEVEL_W-1:0] lvl);
        logic [15:0] prod;
        prod = 16'(c) * 16'(lvl);
        if (lvl == '0) begin
            return c;
        end
        return prod[15:8];
    endfunction

    // check, store brightness, scale and pack; one result per item
    function automatic rsp_t format_req(input req_t r);
        rsp_t               res;
        status_t            st;
        logic [LEVEL_W-1:0] lvl;
        logic [4:0]         wpos, rpos, gpos, bpos;
        logic [31:0]        word, idx;
        res = '0;
        if (r.channel >= cfg_mirror.num_channels || r.channel >= MAX_CH) begin
            st = STATUS_BAD_CHANNEL;
        end else if (r.channel >= ENABLE_W) begin
            st = STATUS_DISABLED;
        end else if (!cfg_mirror.channel_enable[r.channel[3:0]]) begin
            st = STATUS_DISABLED;
        end else begin
            st = STATUS_OK;
        end
        if (r.req_type == REQ_BRIGHTNESS) begin
            if (st == STATUS_OK) begin
                level_mirror[r.channel[3:0]] = r.level;
            end
        end else begin
            if (st == STATUS_OK && r.led_index >= cfg_mirror.num_leds) begin
                st = STATUS_LED_RANGE;
            end
            if (st == STATUS_OK) begin
                lvl  = level_mirror[r.channel[3:0]];
                wpos = {cfg_mirror.color_order[7:6], 3'b000};
                rpos = {cfg_mirror.color_order[5:4], 3'b000};
                gpos = {cfg_mirror.color_order[3:2], 3'b000};
                bpos = {cfg_mirror.color_order[1:0], 3'b000};
                word = (32'(dim_color(r.red, lvl)) << rpos)
                     | (32'(dim_color(r.green, lvl)) << gpos)
                     | (32'(dim_color(r.blue, lvl)) << bpos);
                // white shares red's byte => 24-bit string, white dropped
                if (wpos != rpos) begin
                    word = word | (32'(dim_color(r.white, lvl)) << wpos);
                end
                idx = 32'(cfg_mirror.num_channels) * 32'(r.led_index) + 32'(r.channel);
                res.write_valid = 1'b1;
                res.word_index  = idx[WIDX_W-1:0];
                res.pixel_word  = word;
            end
        end
        res.status = st;
        return res;
    endfunction

    function automatic req_t pixel_req(input logic [4:0] ch, input logic [15:0] led,
                                       input logic [31:0] rgbw);
        req_t r;
        r = '0;
        r.req_type  = REQ_PIXEL;
        r.channel   = ch;
        r.led_index = led;
        {r.red, r.green, r.blue, r.white} = rgbw;
        r.level     = 8'($urandom);
        return r;
    endfunction

    function automatic req_t level_req(input logic [4:0] ch, input logic [7:0] lvl);
        req_t r;
        r = '0;
        r.req_type  = REQ_BRIGHTNESS;
        r.channel   = ch;
        r.level     = lvl;
        r.led_index = 16'($urandom);
        r.red       = 8'($urandom);
        return r;
    endfunction

    // mostly items that pass the checks, the rest any value at all
    function automatic req_t rand_req();
        req_t r;
        int   lim;
        r.req_type  = ($urandom_range(3) == 0) ? REQ_BRIGHTNESS : REQ_PIXEL;
        r.red       = 8'($urandom);
        r.green     = 8'($urandom);
        r.blue      = 8'($urandom);
        r.white     = 8'($urandom);
        case ($urandom_range(7))
            0: r.level = 8'h00;
            1: r.level = 8'hFF;
            default: r.level = 8'($urandom);
        endcase
        lim = (cfg_mirror.num_channels > MAX_CH) ? MAX_CH : cfg_mirror.num_channels;
        if ($urandom_range(4) == 0 || lim == 0) begin
            r.channel   = 5'($urandom_range(31));
            r.led_index = 16'($urandom);
        end else begin
            for (int k = 0; k < 16; k++) begin
                r.channel = 5'($urandom_range(lim - 1));
                if (cfg_mirror.channel_enable[r.channel[3:0]]) begin
                    break;
                end
            end
            if (cfg_mirror.num_leds == 0) begin
                r.led_index = 16'($urandom_range(3));
            end else begin
                case ($urandom_range(9))
                    0: r.led_index = '0;
                    1: r.led_index = 16'(cfg_mirror.num_leds) - 16'd1;
                    2: r.led_index = 16'(cfg_mirror.num_leds);
                    default: r.led_index = 16'($urandom_range(cfg_mirror.num_leds - 1));
                endcase
            end
        end
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NUM_CHANNELS:   cfg_mirror.num_channels   = val[NUM_CH_W-1:0];
            REG_CHANNEL_ENABLE: cfg_mirror.channel_enable = val[ENABLE_W-1:0];
            REG_NUM_LEDS:       cfg_mirror.num_leds       = val[NUM_LEDS_W-1:0];
            REG_COLOR_ORDER:    cfg_mirror.color_order    = val[ORDER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_cfg(input logic [4:0] nch, input logic [15:0] en,
                           input logic [14:0] nleds, input logic [7:0] order);
        write_reg(REG_NUM_CHANNELS, 32'(nch));
        write_reg(REG_CHANNEL_ENABLE, 32'(en));
        write_reg(REG_NUM_LEDS, 32'(nleds));
        write_reg(REG_COLOR_ORDER, 32'(order));
    endtask

    task automatic wait_drained();
        while (pixel_reqs_q.size() != 0 || s_valid || formatted_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(input int n);
        repeat (n) pixel_reqs_q.push_back(rand_req());
        wait_drained();
    endtask

    task automatic note_fail(input string msg);
        if (fail_cnt < 10) begin
            $display("%0t: %s", $time, msg);
        end
        fail_cnt++;
    endtask

    // sender: bursts of items with random gaps, no gaps while the receiver holds off
    always @(posedge aclk) begin : feed
        req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                formatted_q.push_back(format_req('{s_req_type, s_channel, s_led_index,
                    s_red, s_green, s_blue, s_white, s_level}));
                accepted_cnt++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 && hold_left == 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pixel_reqs_q.size() != 0) begin
                    nxt = pixel_reqs_q.pop_front();
                    s_valid     <= 1'b1;
                    s_req_type  <= nxt.req_type;
                    s_channel   <= nxt.channel;
                    s_led_index <= nxt.led_index;
                    s_red       <= nxt.red;
                    s_green     <= nxt.green;
                    s_blue      <= nxt.blue;
                    s_white     <= nxt.white;
                    s_level     <= nxt.level;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(5))
                            0, 1: gap_left = 0;
                            2, 3: gap_left = $urandom_range(1, 4);
                            4:    gap_left = $urandom_range(5, 12);
                            default: gap_left = 25;
                        endcase
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall pattern, plus one long hold-off to back up the pipe
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && accepted_cnt >= 120 && pixel_reqs_q.size() >= 10) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready    <= stall_pat[0];
            stall_tick <= stall_tick + 4'd1;
            if (stall_tick == '0) begin
                case ($urandom_range(3))
                    0: stall_pat <= 16'hFFFF;
                    1: stall_pat <= 16'($urandom);
                    2: stall_pat <= 16'($urandom) | 16'($urandom);
                    default: stall_pat <= 16'($urandom) & 16'($urandom);
                endcase
            end else begin
                stall_pat <= {stall_pat[0], stall_pat[15:1]};
            end
        end
    end

    always @(posedge aclk) begin : result_check
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (formatted_q.size() == 0) begin
                note_fail($sformatf("result %0d with no item waiting: status %0d word %h",
                    rsp_cnt, m_status, m_pixel_word));
            end else begin
                want = formatted_q.pop_front();
                if (m_status !== want.status || m_write_valid !== want.write_valid ||
                    m_word_index !== want.word_index || m_pixel_word !== want.pixel_word) begin
                    note_fail($sformatf({"result %0d mismatch (exp/got): status %0d/%0d ",
                        "write %0b/%0b index %0d/%0d word %h/%h"}, rsp_cnt,
                        want.status, m_status, want.write_valid, m_write_valid,
                        want.word_index, m_word_index, want.pixel_word, m_pixel_word));
                end
            end
            rsp_cnt++;
        end
    end

    initial begin
        for (cycle_cnt = 0; cycle_cnt < RUN_LIMIT; cycle_cnt++) begin
            @(posedge aclk);
        end
        $display("timeout after %0d cycles", RUN_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        cfg_mirror = '{num_channels: 5'd1, default: '0};
        foreach (level_mirror[i]) level_mirror[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: one channel, none enabled
        pixel_reqs_q.push_back(pixel_req(5'd0, 16'd0, 32'h11223344));
        pixel_reqs_q.push_back(level_req(5'd0, 8'h40));
        pixel_reqs_q.push_back(pixel_req(5'd1, 16'd0, 32'h55667788));
        wait_drained();

        // channels 0, 1, 3 wired, channel 2 not
        set_cfg(5'd4, 16'h000B, 15'd10, 8'b11_10_01_00);
        pixel_reqs_q.push_back(level_req(5'd0, 8'h80));
        pixel_reqs_q.push_back(pixel_req(5'd0, 16'd0, 32'hFFFFFFFF));
        pixel_reqs_q.push_back(pixel_req(5'd1, 16'd9, 32'h12345678));
        pixel_reqs_q.push_back(pixel_req(5'd1, 16'd10, 32'h12345678));
        pixel_reqs_q.push_back(pixel_req(5'd1, 16'hFFFF, 32'h12345678));
        // channel check wins over the LED check, mask check too
        pixel_reqs_q.push_back(pixel_req(5'd4, 16'd100, 32'hA5A5A5A5));
        pixel_reqs_q.push_back(pixel_req(5'd2, 16'd100, 32'hA5A5A5A5));
        // rejected level write must leave channel 2 at zero
        pixel_reqs_q.push_back(level_req(5'd2, 8'h55));
        pixel_reqs_q.push_back(level_req(5'd3, 8'hFF));
        pixel_reqs_q.push_back(pixel_req(5'd3, 16'd5, 32'hFF0180C8));
        pixel_reqs_q.push_back(level_req(5'd3, 8'h01));
        pixel_reqs_q.push_back(pixel_req(5'd3, 16'd5, 32'hFFFFFFFF));
        pixel_reqs_q.push_back(level_req(5'd0, 8'h00));
        pixel_reqs_q.push_back(pixel_req(5'd0, 16'd3, 32'hDEADBEEF));
        wait_drained();

        // zero channels: everything is out of range
        set_cfg(5'd0, 16'hFFFF, 15'h7FFF, 8'hFF);
        pixel_reqs_q.push_back(pixel_req(5'd0, 16'd0, 32'h01020304));
        pixel_reqs_q.push_back(level_req(5'd0, 8'h10));
        wait_drained();

        // count above the channel limit, index wraps, r/g/b overlap in byte 0
        set_cfg(5'd31, 16'hFFFF, 15'h7FFF, 8'b01_00_00_00);
        pixel_reqs_q.push_back(pixel_req(5'd15, 16'd32766, 32'h80402010));
        pixel_reqs_q.push_back(pixel_req(5'd16, 16'd0, 32'h80402010));
        pixel_reqs_q.push_back(pixel_req(5'd31, 16'd0, 32'h80402010));
        pixel_reqs_q.push_back(pixel_req(5'd2, 16'd0, 32'h0FF033AA));
        wait_drained();

        // 24-bit string
        set_cfg(5'd16, 16'hFFFF, 15'd1, 8'b10_10_00_01);
        pixel_reqs_q.push_back(pixel_req(5'd15, 16'd0, 32'hC3A5965A));
        pixel_reqs_q.push_back(pixel_req(5'd0, 16'd1, 32'hC3A5965A));
        wait_drained();

        set_cfg(5'd16, 16'hFFFF, 15'h7FFF, 8'b11_10_01_00);
        run_random(70);
        set_cfg(5'd16, 16'($urandom), 15'd1, 8'b00_01_10_11);
        run_random(70);
        set_cfg(5'd8, 16'($urandom) | 16'h0001, 15'($urandom_range(2, 40)), 8'b01_01_00_10);
        run_random(70);
        set_cfg(5'd17, 16'hFFFF, 15'd20000, 8'($urandom));
        run_random(70);
        set_cfg(5'd31, 16'($urandom), 15'h7FFF, 8'h00);
        run_random(70);
        set_cfg(5'd1, 16'h0001, 15'($urandom_range(1, 300)), 8'($urandom));
        run_random(70);
        set_cfg(5'd3, 16'hFFFE, 15'd0, 8'($urandom));
        run_random(60);
        set_cfg(5'($urandom_range(1, 31)), 16'($urandom), 15'($urandom), 8'($urandom));
        run_random(80);

        repeat (10) @(posedge aclk);
        if (fail_cnt == 0 && formatted_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
